>>> hdl/pipc_pkg.sv
// ---------------------------------------------------------------------------
// pipc_pkg
// Shared types and constants for the PI position loop.
// ---------------------------------------------------------------------------
package pipc_pkg;

    localparam int SETPOINT_W = 8;
    localparam int POSITION_W = 8;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [POSITION_W-1:0] POS_MAX = 8'hFF;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_PROP_SHIFT     = 2'd0;
    localparam logic [1:0] REG_INTEGRAL_SHIFT = 2'd1;
    localparam logic [1:0] REG_OUTPUT_SHIFT   = 2'd2;

    localparam logic [2:0] PROP_SHIFT_RST     = 3'd1;
    localparam logic [3:0] INTEGRAL_SHIFT_RST = 4'd5;
    localparam logic [3:0] OUTPUT_SHIFT_RST   = 4'd6;

    typedef struct packed {
        logic [2:0] prop_shift;
        logic [3:0] integral_shift;
        logic [3:0] output_shift;
    } cfg_t;

endpackage

>>> hdl/pipc_if.sv
// ---------------------------------------------------------------------------
// pipc_if
// Valid/ready channels for setpoint words and position words.
// ---------------------------------------------------------------------------
interface pipc_in_if;
    logic                             valid;
    logic                             ready;
    logic [pipc_pkg::SETPOINT_W-1:0]  setpoint;

    modport source (output valid, output setpoint, input ready);
    modport sink   (input valid, input setpoint, output ready);
endinterface

interface pipc_out_if;
    logic                             valid;
    logic                             ready;
    logic [pipc_pkg::POSITION_W-1:0]  position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

>>> hdl/pipc_cfg.sv
// ---------------------------------------------------------------------------
// pipc_cfg
// APB register file: gain shifts for the PI loop.
// ---------------------------------------------------------------------------
module pipc_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pipc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pipc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pipc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output pipc_pkg::cfg_t                  cfg
);

    pipc_pkg::cfg_t cfg_reg;
    pipc_pkg::cfg_t cfg_next;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                pipc_pkg::REG_PROP_SHIFT:     cfg_next.prop_shift     = pwdata[2:0];
                pipc_pkg::REG_INTEGRAL_SHIFT: cfg_next.integral_shift = pwdata[3:0];
                pipc_pkg::REG_OUTPUT_SHIFT:   cfg_next.output_shift   = pwdata[3:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            pipc_pkg::REG_PROP_SHIFT:
                prdata = {29'd0, cfg_reg.prop_shift};
            pipc_pkg::REG_INTEGRAL_SHIFT:
                prdata = {28'd0, cfg_reg.integral_shift};
            pipc_pkg::REG_OUTPUT_SHIFT:
                prdata = {28'd0, cfg_reg.output_shift};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_shift     <= pipc_pkg::PROP_SHIFT_RST;
            cfg_reg.integral_shift <= pipc_pkg::INTEGRAL_SHIFT_RST;
            cfg_reg.output_shift   <= pipc_pkg::OUTPUT_SHIFT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/pipc_step.sv
// ---------------------------------------------------------------------------
// pipc_step
// One PI update: error, integral, drive, accumulator and position clamp.
// ---------------------------------------------------------------------------
module pipc_step
#(
    parameter int FRAC_BITS = 16,
    parameter int ACC_WIDTH = 40
)
(
    input  pipc_pkg::cfg_t                   cfg,
    input  logic [pipc_pkg::SETPOINT_W-1:0]  setpoint,
    input  logic signed [ACC_WIDTH-1:0]      isum,
    input  logic signed [ACC_WIDTH-1:0]      oacc,
    input  logic [FRAC_BITS+7:0]             pos_frac,
    output logic signed [ACC_WIDTH-1:0]      isum_next,
    output logic signed [ACC_WIDTH-1:0]      oacc_next,
    output logic [FRAC_BITS+7:0]             pos_frac_next,
    output logic [pipc_pkg::POSITION_W-1:0]  position
);

    localparam int POS_W = FRAC_BITS + 8;
    // headroom for sums of two accumulator values and err << 7
    localparam int EW    = ACC_WIDTH + 9;

    localparam logic signed [EW-1:0] ACC_MAX_E =
        signed'({{(EW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}});
    localparam logic signed [EW-1:0] ACC_MIN_E = ~ACC_MAX_E;
    localparam logic signed [EW-1:0] TOP_E =
        signed'({{(EW-POS_W){1'b0}}, pipc_pkg::POS_MAX, {FRAC_BITS{1'b0}}});

    function automatic logic signed [ACC_WIDTH-1:0] sat(input logic signed [EW-1:0] x);
        logic signed [ACC_WIDTH-1:0] r;
        begin
            if (x > ACC_MAX_E)
                r = ACC_MAX_E[ACC_WIDTH-1:0];
            else if (x < ACC_MIN_E)
                r = ACC_MIN_E[ACC_WIDTH-1:0];
            else
                r = x[ACC_WIDTH-1:0];
            return r;
        end
    endfunction

    logic signed [EW-1:0]        sp_e;
    logic signed [EW-1:0]        pos_e;
    logic signed [ACC_WIDTH-1:0] err;
    logic signed [EW-1:0]        err_e;
    logic signed [ACC_WIDTH-1:0] prop;
    logic signed [ACC_WIDTH-1:0] isum_sh;
    logic signed [ACC_WIDTH-1:0] drive;
    logic signed [ACC_WIDTH-1:0] drive_sh;
    logic signed [EW-1:0]        oacc_e;

    assign sp_e  = signed'({{(EW-POS_W){1'b0}}, setpoint, {FRAC_BITS{1'b0}}});
    assign pos_e = signed'({{(EW-POS_W){1'b0}}, pos_frac});

    assign err       = sat(sp_e - pos_e);
    assign err_e     = EW'(err);
    assign isum_next = sat(EW'(isum) + err_e);

    assign prop    = sat(err_e <<< cfg.prop_shift);
    assign isum_sh = isum_next >>> cfg.integral_shift;
    assign drive   = sat(EW'(prop) + EW'(isum_sh));

    assign drive_sh  = drive >>> cfg.output_shift;
    assign oacc_next = sat(EW'(oacc) + EW'(drive_sh));
    assign oacc_e    = EW'(oacc_next);

    always_comb
    begin
        if (oacc_e < 0)
            pos_frac_next = '0;
        else if (oacc_e > TOP_E)
            pos_frac_next = TOP_E[POS_W-1:0];
        else
            pos_frac_next = oacc_e[POS_W-1:0];
    end

    assign position = pos_frac_next[POS_W-1:FRAC_BITS];

endmodule

>>> hdl/pi_position_loop_with_clamp_top.sv
// ---------------------------------------------------------------------------
// pi_position_loop_with_clamp_top
// Incremental PI position loop with clamped position output.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : setpoint words (8-bit unsigned target position), valid/ready.
//   out_ch : position words (integer part of the clamped position).
//   APB    : prop_shift @0x0, integral_shift @0x4, output_shift @0x8.
//            Write only while the loop is idle; pready is tied high.
// Each accepted setpoint produces exactly one position word.
// Throughput: one setpoint per cycle while in_ch.ready is high. The whole
//   update (error, integral, drive, accumulator, clamp) is a single pass
//   through pipc_step, and the loop state (integral, accumulator,
//   fractional position) is written at the accepting edge, so the next
//   setpoint sees it right away. Each word is registered in the buffer.
// Stalls: results drop into a two-word output buffer; in_ch.ready stays
//   high while a slot is free, so one more setpoint is taken while a word
//   waits. ready falls only when both words are waiting.
// Reset (rst_n, async low): loop state cleared to zero, buffer emptied,
//   registers back to 1/5/6.
// ---------------------------------------------------------------------------
module pi_position_loop_with_clamp_top
#(
    parameter int FRAC_BITS = 16,
    parameter int ACC_WIDTH = 40
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    pipc_in_if.sink                         in_ch,
    pipc_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pipc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pipc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pipc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int POS_W = FRAC_BITS + 8;

    pipc_pkg::cfg_t cfg;

    // loop state
    logic signed [ACC_WIDTH-1:0] isum_reg;
    logic signed [ACC_WIDTH-1:0] oacc_reg;
    logic [POS_W-1:0]            pos_reg;
    logic signed [ACC_WIDTH-1:0] isum_next;
    logic signed [ACC_WIDTH-1:0] oacc_next;
    logic [POS_W-1:0]            pos_next;
    logic [pipc_pkg::POSITION_W-1:0] position;

    // output buffer: head word, second word, fill count 0..2
    logic [pipc_pkg::POSITION_W-1:0] q0_reg;
    logic [pipc_pkg::POSITION_W-1:0] q1_reg;
    logic [1:0]                      cnt_reg;
    logic                            push;
    logic                            pop;

    pipc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pipc_step #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_step (
        .cfg           (cfg),
        .setpoint      (in_ch.setpoint),
        .isum          (isum_reg),
        .oacc          (oacc_reg),
        .pos_frac      (pos_reg),
        .isum_next     (isum_next),
        .oacc_next     (oacc_next),
        .pos_frac_next (pos_next),
        .position      (position)
    );

    assign in_ch.ready     = (cnt_reg != 2'd2);
    assign out_ch.valid    = (cnt_reg != 2'd0);
    assign out_ch.position = q0_reg;

    assign push = in_ch.valid & in_ch.ready;
    assign pop  = out_ch.valid & out_ch.ready;

    // state advances only on an accepted setpoint
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isum_reg <= '0;
            oacc_reg <= '0;
            pos_reg  <= '0;
        end
        else if (push)
        begin
            isum_reg <= isum_next;
            oacc_reg <= oacc_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push & ~pop)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (pop & ~push)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // buffer payload, no reset needed
    always_ff @(posedge clk)
    begin
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    q0_reg <= position;
                else
                    q1_reg <= position;
            end
            2'b01:
            begin
                q0_reg <= q1_reg;
            end
            2'b11:
            begin
                // push with pop implies one word held
                q0_reg <= position;
            end
            default:
            begin
                q0_reg <= q0_reg;
            end
        endcase
    end

endmodule

>>> hdl/pipc_chk.sv
// ---------------------------------------------------------------------------
// pipc_chk
// Port-level checks for the PI position loop, bound to the top level.
// ---------------------------------------------------------------------------
module pipc_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_position
);

    // stalled word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("position word dropped while stalled");

    // stalled word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_position))
        else $error("position word changed while stalled");

    // after an accepted setpoint, a word is offered in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no position word after accepted setpoint");

    // no word appears from an empty buffer without a setpoint
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("position word without a setpoint");

    // input blocked only while a word is offered
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with empty output");

endmodule

bind pi_position_loop_with_clamp_top pipc_chk u_pipc_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_position (out_ch.position)
);
